FILE: design/esd_pkg.sv
package esd_pkg;

    localparam int SAMPLE_W = 32;
    localparam int PERIOD_W = 7;
    localparam int ALPHA_W  = 17;
    localparam int SUM_W    = 38;
    localparam int ACC_W    = ALPHA_W + SAMPLE_W;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    localparam logic [ALPHA_W-1:0]   ONE_Q16      = 17'h10000;
    localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 7'd14;
    localparam logic [ALPHA_W-1:0]   ALPHA_RESET  = 17'd8738;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 1'b1;

    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_LOAD,
        MAC_ADD
    } t_mac_op;

endpackage

FILE: design/esd_if.sv
interface esd_in_if;
    import esd_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                series_last;

    modport source (output valid, output sample, output series_last, input ready);
    modport sink   (input valid, input sample, input series_last, output ready);
endinterface

interface esd_out_if;
    import esd_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] ema_value;
    logic                defined;
    logic                run_last;
    logic                series_end;

    modport source (output valid, output ema_value, output defined, output run_last,
                    output series_end, input ready);
    modport sink   (input valid, input ema_value, input defined, input run_last,
                    input series_end, output ready);
endinterface

FILE: design/esd_mac.sv
module esd_mac
    import esd_pkg::*;
(
    input  logic                i_clk,
    input  t_mac_op             i_op,
    input  logic [ALPHA_W-1:0]  i_coef,
    input  logic [SAMPLE_W-1:0] i_data,
    output logic [ACC_W-1:0]    o_acc
);

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] w_prod;

    // One 17 x 32 product per cycle; the two terms of the recurrence
    // are summed by a load followed by an add.
    assign w_prod = ACC_W'(i_coef) * ACC_W'(i_data);

    always_ff @(posedge i_clk) begin
        case (i_op)
            MAC_LOAD: r_acc <= w_prod;
            MAC_ADD:  r_acc <= r_acc + w_prod;
            default:  r_acc <= r_acc;
        endcase
    end

    assign o_acc = r_acc;

endmodule

FILE: design/esd_div.sv
module esd_div
    import esd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SUM_W-1:0]    i_dividend,
    input  logic [PERIOD_W-1:0] i_divisor,
    output logic                o_done,
    output logic [SUM_W-1:0]    o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_q;
    logic [PERIOD_W:0]    r_rem;
    logic [PERIOD_W-1:0]  r_div;
    logic [PERIOD_W:0]    w_trial;
    logic                 w_fit;

    // Restoring division, one quotient bit per cycle.
    assign w_trial = {r_rem[PERIOD_W-1:0], r_q[SUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(SUM_W - 1);
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_fit ? (w_trial - {1'b0, r_div}) : w_trial;
                r_q   <= {r_q[SUM_W-2:0], w_fit};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: design/ema_with_average_seed_core.sv
// Steady state (series seeded): S_MUL1 and S_MUL2, the two passes through the shared 17 x 32
// multiply-accumulate unit, then S_EMIT. A warm-up sample that gives no result stays in S_IDLE.
// Seeding gives undefined beats in S_WARM, the 38-step serial divide and the seed beat. A short
// flushed series steps S_RD, S_RDW, S_MUL1 and S_MUL2 (not for the first entry), S_EMIT per entry.
// Reset is synchronous and active low; it clears control state, counters and series registers.
// The warm-up buffer is not cleared; only entries written in the current series are read.
module ema_with_average_seed_core
    import esd_pkg::*;
#(
    parameter int MAX_PERIOD = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    esd_in_if.sink               i_in,
    esd_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ALPHA_W-1:0]   i_cfg_data
);

    localparam int AW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
    localparam logic [PERIOD_W-1:0] MAX_P = PERIOD_W'(MAX_PERIOD);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ZERO,
        S_WARM,
        S_DIV,
        S_SEED,
        S_RD,
        S_RDW,
        S_MUL1,
        S_MUL2,
        S_EMIT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [PERIOD_W-1:0] r_period;
    logic [ALPHA_W-1:0]  r_alpha;

    // Series state.
    logic [PERIOD_W-1:0] r_count;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_prev;
    logic                r_seeded;

    // Per-item working registers.
    logic [SAMPLE_W-1:0] r_x;
    logic                r_last;
    logic                r_fb;
    logic [PERIOD_W-1:0] r_i;

    // Warm-up buffer.
    logic [SAMPLE_W-1:0] r_store [MAX_PERIOD];
    logic [SAMPLE_W-1:0] r_rd_data;

    // Output register.
    logic                r_ovalid;
    logic [SAMPLE_W-1:0] r_oval;
    logic                r_odef;
    logic                r_orl;
    logic                r_ose;

    logic [PERIOD_W-1:0] w_p;
    logic [ALPHA_W-1:0]  w_a;
    logic [PERIOD_W-1:0] w_count_eff;
    logic                w_can_store;
    logic                w_accept;
    logic                w_out_free;
    logic                w_emit;
    logic                w_fb_final;
    logic                w_final;
    logic [SAMPLE_W-1:0] w_res;

    t_mac_op             w_mac_op;
    logic [ALPHA_W-1:0]  w_coef;
    logic [SAMPLE_W-1:0] w_mac_data;
    logic [ACC_W-1:0]    w_acc;

    logic                w_div_start;
    logic                w_div_done;
    logic [SUM_W-1:0]    w_quot;

    // A period above the buffer depth acts as the depth, an alpha above one acts as one.
    assign w_p = (r_period > MAX_P) ? MAX_P : r_period;
    assign w_a = (r_alpha > ONE_Q16) ? ONE_Q16 : r_alpha;

    assign w_can_store = (r_count < MAX_P);
    assign w_count_eff = w_can_store ? (r_count + 1'b1) : r_count;

    assign w_accept   = i_in.valid && (r_state == S_IDLE);
    assign w_out_free = !r_ovalid || o_out.ready;

    // A new beat is loaded into the output register in this cycle.
    assign w_emit = w_out_free && ((r_state inside {S_ZERO, S_SEED, S_EMIT}) ||
                                   ((r_state == S_WARM) && (r_i < r_count)));

    // In the short-series flush, the last buffered entry carries the run's final beat.
    assign w_fb_final = (r_i == (r_count - 1'b1));
    assign w_final    = r_fb ? w_fb_final : 1'b1;

    // The first flushed result is the first sample itself; every other one comes from the MAC.
    assign w_res = (r_fb && (r_i == '0)) ? r_rd_data : w_acc[SAMPLE_W+15:16];

    // The shared unit forms alpha*x in the first pass and adds (one-alpha)*prev in the second.
    always_comb begin
        w_mac_op   = MAC_HOLD;
        w_coef     = w_a;
        w_mac_data = r_fb ? r_rd_data : r_x;
        case (r_state)
            S_MUL1: begin
                w_mac_op = MAC_LOAD;
            end
            S_MUL2: begin
                w_mac_op   = MAC_ADD;
                w_coef     = ONE_Q16 - w_a;
                w_mac_data = r_prev;
            end
            default: begin
                w_mac_op = MAC_HOLD;
            end
        endcase
    end

    assign w_div_start = (r_state == S_WARM) && (r_i >= r_count);

    esd_mac u_mac (
        .i_clk  (i_clk),
        .i_op   (w_mac_op),
        .i_coef (w_coef),
        .i_data (w_mac_data),
        .o_acc  (w_acc)
    );

    esd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // The buffer is written when a warm-up sample is accepted and read every cycle at the
    // flush index, so the data is ready in the cycle after the index is set.
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_p != '0) && !r_seeded && w_can_store) begin
            r_store[r_count[AW-1:0]] <= i_in.sample;
        end
        r_rd_data <= r_store[r_i[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_alpha  <= ALPHA_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PERIOD: r_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_ALPHA:  r_alpha  <= i_cfg_data;
                default:    r_alpha  <= r_alpha;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_sum    <= '0;
            r_prev   <= '0;
            r_seeded <= 1'b0;
            r_ovalid <= 1'b0;
            r_fb     <= 1'b0;
            r_last   <= 1'b0;
            r_i      <= '0;
        end else begin
            if (o_out.ready && !w_emit) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_x    <= i_in.sample;
                        r_last <= i_in.series_last;
                        // Only a series that ends before its seed takes the flush path.
                        r_fb   <= (w_p != '0) && !r_seeded && (w_count_eff < w_p) &&
                                  i_in.series_last;
                        if (w_p == '0) begin
                            r_state <= S_ZERO;
                        end else if (r_seeded) begin
                            r_state <= S_MUL1;
                        end else begin
                            if (w_can_store) begin
                                r_count <= w_count_eff;
                                r_sum   <= r_sum + SUM_W'(i_in.sample);
                            end
                            if (w_count_eff >= w_p) begin
                                r_i     <= PERIOD_W'(1);
                                r_state <= S_WARM;
                            end else if (i_in.series_last) begin
                                r_i     <= '0;
                                r_state <= S_RD;
                            end
                        end
                    end
                end
                S_ZERO: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= '0;
                        r_odef   <= 1'b0;
                        r_orl    <= 1'b1;
                        r_ose    <= r_last;
                        r_state  <= S_IDLE;
                        if (r_last) begin
                            r_count  <= '0;
                            r_sum    <= '0;
                            r_prev   <= '0;
                            r_seeded <= 1'b0;
                        end
                    end
                end
                S_WARM: begin
                    // Undefined beats for every buffered sample but the last, then the divide.
                    if (r_i >= r_count) begin
                        r_state <= S_DIV;
                    end else if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= '0;
                        r_odef   <= 1'b0;
                        r_orl    <= 1'b0;
                        r_ose    <= 1'b0;
                        r_i      <= r_i + 1'b1;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_prev   <= w_quot[SAMPLE_W-1:0];
                        r_seeded <= 1'b1;
                        r_state  <= S_SEED;
                    end
                end
                S_SEED: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= r_prev;
                        r_odef   <= 1'b1;
                        r_orl    <= 1'b1;
                        r_ose    <= r_last;
                        r_state  <= S_IDLE;
                        if (r_last) begin
                            r_count  <= '0;
                            r_sum    <= '0;
                            r_prev   <= '0;
                            r_seeded <= 1'b0;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_RDW;
                end
                S_RDW: begin
                    r_state <= (r_i == '0) ? S_EMIT : S_MUL1;
                end
                S_MUL1: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= w_res;
                        r_odef   <= 1'b1;
                        r_orl    <= w_final;
                        r_ose    <= w_final && r_last;
                        if (w_final) begin
                            r_state <= S_IDLE;
                            if (r_last) begin
                                r_count  <= '0;
                                r_sum    <= '0;
                                r_prev   <= '0;
                                r_seeded <= 1'b0;
                            end else begin
                                r_prev   <= w_res;
                            end
                        end else begin
                            r_prev  <= w_res;
                            r_i     <= r_i + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_ovalid;
    assign o_out.ema_value  = r_oval;
    assign o_out.defined    = r_odef;
    assign o_out.run_last   = r_orl;
    assign o_out.series_end = r_ose;

endmodule
